// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the SPH kernel block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- hw/rtl/sphk_pkg.sv -----
// Shared types, codes and helpers of the SPH cubic spline kernel block.
`timescale 1ns / 1ps
package sphk_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SAT_W         = 72;

    // register reset values, given in Q16.16 and rescaled to the chosen format
    localparam longint RST_FW_Q16     = 119206;
    localparam longint RST_FG_MAG_Q16 = 715236;

    typedef enum logic [1:0] {
        REGION_INNER   = 2'd0,
        REGION_OUTER   = 2'd1,
        REGION_OUTSIDE = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        CFG_RECIP_H     = 2'd0,
        CFG_FACTOR_W    = 2'd1,
        CFG_FACTOR_GRAD = 2'd2
    } t_cfg_index;

    // values that ride alongside the divider
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] f_inner;
        logic [31:0]        qrh;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        t_region            region;
    } t_tail;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] f;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        t_region            region;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi_lim;
        logic signed [SAT_W-1:0] lo_lim;
        hi_lim = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
        lo_lim = {{(SAT_W-31){1'b1}}, {31{1'b0}}};
        if (v > hi_lim) begin
            return {1'b0, {31{1'b1}}};
        end else if (v < lo_lim) begin
            return {1'b1, {31{1'b0}}};
        end
        return v[31:0];
    endfunction

endpackage

// ----- hw/rtl/sph_cubic_spline_kernel.sv -----
// Top level of the 2D cubic B-spline SPH kernel: W, F and gradient for one pair.
// Throughput: one pair per cycle while the skid entry is empty; the depth is set by the bit-per-stage 1/d divider.
// The output register plus one skid entry let the pipe advance under a stalled output.
// Reset (synchronous, active low) empties all stages and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sph_cubic_spline_kernel #(
    parameter int FRAC_BITS = sphk_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pair input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_distance,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_kernel_value,
    output logic signed [31:0] o_radial_factor,
    output logic signed [31:0] o_grad_x,
    output logic signed [31:0] o_grad_y,
    output logic [1:0]         o_region,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int QW   = 2 * F + 1;        // quotient bits of 2^(2F)/d
    localparam int NSTG = QW + 6;           // pipeline stages ahead of the output buffer
    localparam int DLY  = QW - 5;           // side-value delay that matches the divider
    localparam int SW   = ((QW > 33) ? QW : 33) + 2;
    localparam int MW   = 32 + F;           // clamped |s| width
    localparam int CW   = ((SW > MW) ? SW : MW) + 1;
    localparam int TW   = $bits(sphk_pkg::t_tail);

    localparam logic [31:0] RST_RH = 32'(64'(1) << F);
    localparam logic [31:0] RST_FW = 32'((64'(sphk_pkg::RST_FW_Q16) << F) >> 16);
    localparam logic [31:0] RST_FG =
        32'(64'(0) - ((64'(sphk_pkg::RST_FG_MAG_Q16) << F) >> 16));
    localparam logic [F-1:0] LOW_MASK = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]        r_recip_h;
    logic [31:0]        r_factor_w;
    logic signed [31:0] r_factor_grad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip_h     <= RST_RH;
            r_factor_w    <= RST_FW;
            r_factor_grad <= RST_FG;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sphk_pkg::CFG_RECIP_H:     r_recip_h     <= i_cfg_data;
                sphk_pkg::CFG_FACTOR_W:    r_factor_w    <= i_cfg_data;
                sphk_pkg::CFG_FACTOR_GRAD: r_factor_grad <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipe advances unless the skid entry is
    // occupied, so the input side never waits on i_out_stall directly.
    // ------------------------------------------------------------------
    logic            r_skid_v;
    logic            r_out_v;
    logic            w_en;
    logic [NSTG-1:0] r_v;

    assign w_en       = !r_skid_v;
    assign o_in_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NSTG-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the pair
    // ------------------------------------------------------------------
    logic [31:0]        r1_d;
    logic signed [31:0] r1_vx, r1_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d  <= i_distance;
            r1_vx <= i_vec_x;
            r1_vy <= i_vec_y;
        end
    end

    // ------------------------------------------------------------------
    // Divider for 1/d runs beside stages 2 .. QW+1
    // ------------------------------------------------------------------
    logic [QW-1:0] w_quot;

    sphk_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_divisor (r1_d),
        .o_quot    (w_quot)
    );

    // ------------------------------------------------------------------
    // Stage 2: exact product P = d * recip_h
    // ------------------------------------------------------------------
    logic [63:0]        r2_p;
    logic signed [31:0] r2_vx, r2_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p  <= 64'(r1_d) * 64'(r_recip_h);
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: region, q, q*q, q*recip_h and (3q-2)*recip_h
    // ------------------------------------------------------------------
    logic [F-1:0]       w_q;
    sphk_pkg::t_region  w_region;
    logic [F+2:0]       w_q3x;
    logic signed [F+2:0] w_lin;

    always_comb begin
        w_q   = r2_p[F +: F];
        w_q3x = (F+3)'(w_q) * (F+3)'(3);
        w_lin = $signed(w_q3x) - $signed((F+3)'(2) << F);
        if (r2_p < (64'(1) << (2 * F - 1))) begin
            w_region = sphk_pkg::REGION_INNER;
        end else if (r2_p < (64'(1) << (2 * F))) begin
            w_region = sphk_pkg::REGION_OUTER;
        end else begin
            w_region = sphk_pkg::REGION_OUTSIDE;
        end
    end

    logic [F-1:0]         r3_q;
    sphk_pkg::t_region    r3_region;
    logic signed [F+35:0] r3_ti;
    logic [2*F-1:0]       r3_qq;
    logic [F+31:0]        r3_qrh;
    logic signed [31:0]   r3_vx, r3_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_q      <= w_q;
            r3_region <= w_region;
            r3_ti     <= w_lin * $signed({1'b0, r_recip_h});
            r3_qq     <= (2*F)'(w_q) * (2*F)'(w_q);
            r3_qrh    <= (F+32)'(w_q) * (F+32)'(r_recip_h);
            r3_vx     <= r2_vx;
            r3_vy     <= r2_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: q^2, q^3 product, a = 1-q and a*a, truncate the inner term
    // ------------------------------------------------------------------
    logic [F:0]           w_a;
    logic signed [F+35:0] w_tb;

    always_comb begin
        w_a  = ((F+1)'(1) << F) - (F+1)'(r3_q);
        // truncate toward zero: bias negative values before the shift
        w_tb = r3_ti + $signed({36'd0, r3_ti[F+35] ? LOW_MASK : '0});
    end

    logic [F-1:0]       r4_q2;
    logic [2*F-1:0]     r4_q3p;
    logic [F:0]         r4_a;
    logic [2*F+1:0]     r4_aa;
    logic signed [34:0] r4_t;
    logic [31:0]        r4_qrh;
    sphk_pkg::t_region  r4_region;
    logic signed [31:0] r4_vx, r4_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_q2     <= r3_qq[F +: F];
            r4_q3p    <= (2*F)'(r3_qq[F +: F]) * (2*F)'(r3_q);
            r4_a      <= w_a;
            r4_aa     <= (2*F+2)'(w_a) * (2*F+2)'(w_a);
            r4_t      <= 35'(w_tb >>> F);
            r4_qrh    <= r3_qrh[F +: 32];
            r4_region <= r3_region;
            r4_vx     <= r3_vx;
            r4_vy     <= r3_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: inner polynomial, a^3 product, inner F product
    // ------------------------------------------------------------------
    logic [F-1:0]        w_q3;
    logic signed [F+3:0] w_poly;

    always_comb begin
        w_q3   = r4_q3p[F +: F];
        w_poly = $signed((F+4)'(w_q3) * (F+4)'(6)) - $signed((F+4)'(r4_q2) * (F+4)'(6))
                 + $signed((F+4)'(1) << F);
    end

    logic signed [F+3:0] r5_poly;
    logic [2*F+1:0]      r5_a3p;
    logic signed [66:0]  r5_fi;
    logic [31:0]         r5_qrh;
    sphk_pkg::t_region   r5_region;
    logic signed [31:0]  r5_vx, r5_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_poly   <= w_poly;
            r5_a3p    <= (2*F+2)'(r4_aa[F +: F+1]) * (2*F+2)'(r4_a);
            r5_fi     <= r_factor_grad * r4_t;
            r5_qrh    <= r4_qrh;
            r5_region <= r4_region;
            r5_vx     <= r4_vx;
            r5_vy     <= r4_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: W product, saturate the inner F
    // ------------------------------------------------------------------
    logic [F:0]          w_a3;
    logic signed [F+3:0] w_wop;
    logic signed [66:0]  w_fb;

    always_comb begin
        w_a3  = r5_a3p[F +: F+1];
        w_wop = (r5_region == sphk_pkg::REGION_INNER) ? r5_poly
                                                      : $signed((F+4)'(w_a3) << 1);
        w_fb  = r5_fi + $signed({(67-F)'(0), r5_fi[66] ? LOW_MASK : '0});
    end

    logic signed [F+36:0] r6_wp;
    logic signed [31:0]   r6_fin;
    logic [31:0]          r6_qrh;
    sphk_pkg::t_region    r6_region;
    logic signed [31:0]   r6_vx, r6_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_wp     <= $signed({1'b0, r_factor_w}) * w_wop;
            r6_fin    <= sphk_pkg::sat32(sphk_pkg::SAT_W'(w_fb >>> F));
            r6_qrh    <= r5_qrh;
            r6_region <= r5_region;
            r6_vx     <= r5_vx;
            r6_vy     <= r5_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7 .. QW+1: finish W and hold side values until 1/d is ready
    // ------------------------------------------------------------------
    logic signed [F+36:0] w_wb;
    sphk_pkg::t_tail      w_tail_in;
    sphk_pkg::t_tail      w_tail;
    logic [TW-1:0]        w_tail_bits;

    always_comb begin
        w_wb              = r6_wp + $signed({37'd0, r6_wp[F+36] ? LOW_MASK : '0});
        w_tail_in.w       = (r6_region == sphk_pkg::REGION_OUTSIDE)
                            ? 32'sd0 : sphk_pkg::sat32(sphk_pkg::SAT_W'(w_wb >>> F));
        w_tail_in.f_inner = r6_fin;
        w_tail_in.qrh     = r6_qrh;
        w_tail_in.vx      = r6_vx;
        w_tail_in.vy      = r6_vy;
        w_tail_in.region  = r6_region;
    end

    sphk_delay #(
        .WIDTH (TW),
        .DEPTH (DLY)
    ) u_tail_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (w_tail_in),
        .o_data (w_tail_bits)
    );

    assign w_tail = w_tail_bits;

    // ------------------------------------------------------------------
    // Stage QW+2: s = 1/d - 2 recip_h + q recip_h, split into sign and
    // clamped magnitude. Any |s| at or past 2^(31+F) saturates F anyway.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] w_s;
    logic [SW-1:0]        w_smag;
    logic [CW-1:0]        w_smag_c;
    logic [CW-1:0]        w_clamp;

    always_comb begin
        w_s      = $signed(SW'(w_quot)) - $signed(SW'(r_recip_h) << 1)
                   + $signed(SW'(w_tail.qrh));
        w_smag   = w_s[SW-1] ? SW'(-w_s) : SW'(w_s);
        w_smag_c = CW'(w_smag);
        w_clamp  = CW'(1) << (31 + F);
    end

    logic [MW-1:0]      r8_sm;
    logic               r8_neg;
    logic signed [31:0] r8_w, r8_fin;
    sphk_pkg::t_region  r8_region;
    logic signed [31:0] r8_vx, r8_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_sm     <= (w_smag_c >= w_clamp) ? MW'(w_clamp) : MW'(w_smag_c);
            // sign of -factor_grad * s
            r8_neg    <= r_factor_grad[31] ~^ w_s[SW-1];
            r8_w      <= w_tail.w;
            r8_fin    <= w_tail.f_inner;
            r8_region <= w_tail.region;
            r8_vx     <= w_tail.vx;
            r8_vy     <= w_tail.vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage QW+3: |factor_grad| * |s| as two partial products
    // ------------------------------------------------------------------
    logic [31:0] w_fgm;

    assign w_fgm = r_factor_grad[31] ? 32'(-r_factor_grad) : 32'(r_factor_grad);

    logic [63:0]        r9_plo;
    logic [F+31:0]      r9_phi;
    logic               r9_neg;
    logic signed [31:0] r9_w, r9_fin;
    sphk_pkg::t_region  r9_region;
    logic signed [31:0] r9_vx, r9_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_plo    <= 64'(w_fgm) * 64'(r8_sm[31:0]);
            r9_phi    <= (F+32)'(w_fgm) * (F+32)'(r8_sm[MW-1:32]);
            r9_neg    <= r8_neg;
            r9_w      <= r8_w;
            r9_fin    <= r8_fin;
            r9_region <= r8_region;
            r9_vx     <= r8_vx;
            r9_vy     <= r8_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage QW+4: combine, truncate magnitude, saturate, pick F by region
    // ------------------------------------------------------------------
    logic [63+F:0]      w_mag;
    logic [63:0]        w_sh;
    logic signed [31:0] w_fout;
    logic signed [31:0] w_f;

    always_comb begin
        w_mag = {r9_phi, 32'd0} + (64+F)'(r9_plo);
        w_sh  = w_mag[F +: 64];
        if (r9_neg) begin
            w_fout = (w_sh > 64'h8000_0000) ? {1'b1, 31'd0} : 32'(64'd0 - w_sh);
        end else begin
            w_fout = (w_sh > 64'h7fff_ffff) ? {1'b0, {31{1'b1}}} : w_sh[31:0];
        end
        case (r9_region)
            sphk_pkg::REGION_INNER: w_f = r9_fin;
            sphk_pkg::REGION_OUTER: w_f = w_fout;
            default:                w_f = 32'sd0;
        endcase
    end

    logic signed [31:0] r10_f, r10_w;
    sphk_pkg::t_region  r10_region;
    logic signed [31:0] r10_vx, r10_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_f      <= w_f;
            r10_w      <= r9_w;
            r10_region <= r9_region;
            r10_vx     <= r9_vx;
            r10_vy     <= r9_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage QW+5: gradient products
    // ------------------------------------------------------------------
    logic signed [63:0] r11_gx, r11_gy;
    logic signed [31:0] r11_f, r11_w;
    sphk_pkg::t_region  r11_region;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_gx     <= 64'(r10_f) * 64'(r10_vx);
            r11_gy     <= 64'(r10_f) * 64'(r10_vy);
            r11_f      <= r10_f;
            r11_w      <= r10_w;
            r11_region <= r10_region;
        end
    end

    // ------------------------------------------------------------------
    // Stage QW+6: truncate and saturate the gradient
    // ------------------------------------------------------------------
    logic signed [63:0] w_gxb, w_gyb;

    always_comb begin
        w_gxb = r11_gx + $signed({(64-F)'(0), r11_gx[63] ? LOW_MASK : '0});
        w_gyb = r11_gy + $signed({(64-F)'(0), r11_gy[63] ? LOW_MASK : '0});
    end

    sphk_pkg::t_result r12_res;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_res.w      <= r11_w;
            r12_res.f      <= r11_f;
            r12_res.gx     <= sphk_pkg::sat32(sphk_pkg::SAT_W'(w_gxb >>> F));
            r12_res.gy     <= sphk_pkg::sat32(sphk_pkg::SAT_W'(w_gyb >>> F));
            r12_res.region <= r11_region;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry. A result leaving the pipe goes to
    // the output register when it is free or being drained, otherwise it
    // parks in the skid entry, which also holds the pipe.
    // ------------------------------------------------------------------
    sphk_pkg::t_result r_out, r_skid;
    logic              w_push;
    logic              w_take;

    assign w_push = w_en && r_v[NSTG-1];
    assign w_take = r_out_v && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_push;
            end
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            r_out <= r_skid_v ? r_skid : r12_res;
        end else if (w_push) begin
            r_skid <= r12_res;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_kernel_value  = r_out.w;
    assign o_radial_factor = r_out.f;
    assign o_grad_x        = r_out.gx;
    assign o_grad_y        = r_out.gy;
    assign o_region        = r_out.region;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid entry without output entry")
    `ASSERT_IMPLY(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_v), $past(r_out_v && i_out_stall), "skid filled without a stalled output")
    `ASSERT_IMPLY(a_outside_zero, i_clk, i_rst_n, o_out_valid && (o_region == sphk_pkg::REGION_OUTSIDE), (o_kernel_value == 32'sd0) && (o_radial_factor == 32'sd0) && (o_grad_x == 32'sd0) && (o_grad_y == 32'sd0), "nonzero result outside support")

endmodule

// ----- hw/rtl/sphk_div.sv -----
// Pipelined restoring divider: 2^(2*FRAC_BITS) / divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module sphk_div #(
    parameter int FRAC_BITS = sphk_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [31:0]            i_divisor,
    output logic [2*FRAC_BITS:0]   o_quot
);

    localparam int QW = 2 * FRAC_BITS + 1;

    logic [31:0]   r_dvs [QW];
    logic [31:0]   r_rem [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [31:0]   w_dvs;
        logic [31:0]   w_rem;
        logic [QW-1:0] w_quo;
        logic [32:0]   w_trial;
        logic [32:0]   w_diff;
        logic          w_ge;
        logic [31:0]   n_rem;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_dvs = i_divisor;
            assign w_rem = '0;
            assign w_quo = '0;
        end else begin : g_next
            assign w_dvs = r_dvs[k-1];
            assign w_rem = r_rem[k-1];
            assign w_quo = r_quo[k-1];
        end

        // only the top dividend bit is set
        always_comb begin
            w_trial = {w_rem, (k == 0) ? 1'b1 : 1'b0};
            w_diff  = w_trial - {1'b0, w_dvs};
            w_ge    = (w_trial >= {1'b0, w_dvs});
            n_rem   = w_ge ? w_diff[31:0] : w_trial[31:0];
            n_quo   = {w_quo[QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvs[k] <= w_dvs;
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quot = r_quo[QW-1];

endmodule

// ----- hw/rtl/sphk_delay.sv -----
// Enabled delay line that carries side values past the divider.
`timescale 1ns / 1ps
module sphk_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule
